// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/e2g_pkg.sv =====
package e2g_pkg;

   localparam int COORD_W    = 40;
   localparam int ANGLE_W    = 32;
   localparam int HEIGHT_W   = 40;
   localparam int AXIS_W     = 33;
   localparam int FLAT_W     = 31;
   localparam int CSR_DATA_W = 33;
   localparam int CSR_IDX_W  = 1;

   localparam int ITERATIONS_DEF = 10;

   // shared unit widths
   localparam int MUL_W  = 40;
   localparam int PROD_W = 80;
   localparam int ROOT_W = 40;
   localparam int REM_W  = 43;
   localparam int DIV_W  = 70;
   localparam int DVS_W  = 40;
   localparam int CORD_W = 64;
   localparam int ANG_W  = 34;
   localparam int STEP_W = 5;
   localparam int CNT_W  = 7;

   localparam logic [AXIS_W-1:0] AXIS_RESET = 33'd6378137000;
   localparam logic [FLAT_W-1:0] FLAT_RESET = 31'd14400212;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SEMI_MAJOR = 1'b0,
      CSR_FLATTENING = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      OP_E2, OP_XX, OP_YY, OP_R, OP_S2, OP_W, OP_Q, OP_N,
      OP_TM, OP_TD, OP_RR, OP_LAT, OP_SC, OP_HQ, OP_LON
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE, ST_ISSUE, ST_WAIT, ST_FINISH
   } state_type;

   typedef struct packed {
      logic   load;
      logic   start;
      op_type op;
      logic   publish;
   } cmd_type;

   typedef struct packed {
      logic done;
      logic out_busy;
   } status_type;

   // arctan(2^-i) as binary angle, 2^31 = pi
   function automatic logic [29:0] atan_entry(input logic [STEP_W-1:0] step);
      logic [29:0] v;
      unique case (step)
         5'd0:  v = 30'd536870912;
         5'd1:  v = 30'd316933406;
         5'd2:  v = 30'd167458907;
         5'd3:  v = 30'd85004756;
         5'd4:  v = 30'd42667331;
         5'd5:  v = 30'd21354465;
         5'd6:  v = 30'd10679838;
         5'd7:  v = 30'd5340245;
         5'd8:  v = 30'd2670163;
         5'd9:  v = 30'd1335087;
         5'd10: v = 30'd667544;
         5'd11: v = 30'd333772;
         5'd12: v = 30'd166886;
         5'd13: v = 30'd83443;
         5'd14: v = 30'd41722;
         5'd15: v = 30'd20861;
         5'd16: v = 30'd10430;
         5'd17: v = 30'd5215;
         5'd18: v = 30'd2608;
         5'd19: v = 30'd1304;
         5'd20: v = 30'd652;
         5'd21: v = 30'd326;
         5'd22: v = 30'd163;
         5'd23: v = 30'd81;
         5'd24: v = 30'd41;
         5'd25: v = 30'd20;
         5'd26: v = 30'd10;
         5'd27: v = 30'd5;
         5'd28: v = 30'd3;
         5'd29: v = 30'd1;
         5'd30: v = 30'd1;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

   function automatic logic [COORD_W-1:0] coord_mag(input logic signed [COORD_W-1:0] v);
      return v[COORD_W-1] ? COORD_W'(-v) : COORD_W'(v);
   endfunction

endpackage

// ===== rtl/e2g_if.sv =====
interface e2g_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [e2g_pkg::COORD_W-1:0]    ecef_x;
   logic signed [e2g_pkg::COORD_W-1:0]    ecef_y;
   logic signed [e2g_pkg::COORD_W-1:0]    ecef_z;

   modport source (output valid, ecef_x, ecef_y, ecef_z, input ready);
   modport sink   (input valid, ecef_x, ecef_y, ecef_z, output ready);
endinterface

interface e2g_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [e2g_pkg::ANGLE_W-1:0]    latitude;
   logic signed [e2g_pkg::ANGLE_W-1:0]    longitude;
   logic signed [e2g_pkg::HEIGHT_W-1:0]   height;

   modport source (output valid, latitude, longitude, height, input ready);
   modport sink   (input valid, latitude, longitude, height, output ready);
endinterface

// ===== rtl/e2g_ctrl.sv =====
`include "assert_macros.svh"

module e2g_ctrl #(
   parameter int ITERATIONS = e2g_pkg::ITERATIONS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output e2g_pkg::cmd_type     cmd,
   input  e2g_pkg::status_type  status
);
   import e2g_pkg::*;

   localparam int ITER_W = $clog2(ITERATIONS + 1);

   state_type         state_ff, state_in;
   op_type            op_ff, op_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic              last_iter;

   function automatic op_type op_after(input op_type op, input logic last);
      op_type nxt;
      unique case (op)
         OP_E2:   nxt = OP_XX;
         OP_XX:   nxt = OP_YY;
         OP_YY:   nxt = OP_R;
         OP_R:    nxt = OP_S2;
         OP_S2:   nxt = OP_W;
         OP_W:    nxt = OP_Q;
         OP_Q:    nxt = OP_N;
         OP_N:    nxt = OP_TM;
         OP_TM:   nxt = OP_TD;
         OP_TD:   nxt = OP_RR;
         OP_RR:   nxt = OP_LAT;
         OP_LAT:  nxt = OP_SC;
         OP_SC:   nxt = OP_HQ;
         OP_HQ:   nxt = last ? OP_LON : OP_S2;
         default: nxt = OP_E2;
      endcase
      return nxt;
   endfunction

   assign last_iter = (iter_ff == ITER_W'(ITERATIONS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      iter_in  = iter_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_ISSUE;
               op_in    = OP_E2;
               iter_in  = '0;
            end
         end
         ST_ISSUE: state_in = ST_WAIT;
         ST_WAIT: begin
            if (status.done) begin
               state_in = (op_ff == OP_LON) ? ST_FINISH : ST_ISSUE;
               op_in    = op_after(op_ff, last_iter);
               if (op_ff == OP_HQ) begin
                  iter_in = iter_ff + ITER_W'(1);
               end
            end
         end
         ST_FINISH: begin
            if (!status.out_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready   = (state_ff == ST_IDLE);
      cmd.load    = (state_ff == ST_IDLE) && req_valid;
      cmd.start   = (state_ff == ST_ISSUE);
      cmd.op      = op_ff;
      cmd.publish = (state_ff == ST_FINISH) && !status.out_busy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_E2;
         iter_ff  <= '0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         iter_ff  <= iter_in;
      end
   end

   `ASSERT_ALWAYS(a_reset_idle, reset |=> state_ff == ST_IDLE, "not idle after reset")
   `ASSERT_RST(a_wait_next, (state_ff == ST_WAIT && status.done) |=> (state_ff == ST_ISSUE || state_ff == ST_FINISH), "bad step after unit done")

endmodule

// ===== rtl/e2g_datapath.sv =====
`include "assert_macros.svh"

module e2g_datapath (
   input  logic                                    clock,
   input  logic                                    reset,
   input  e2g_pkg::cmd_type                        cmd,
   output e2g_pkg::status_type                     status,
   input  logic signed [e2g_pkg::COORD_W-1:0]      in_x,
   input  logic signed [e2g_pkg::COORD_W-1:0]      in_y,
   input  logic signed [e2g_pkg::COORD_W-1:0]      in_z,
   input  logic                                    csr_write_en,
   input  logic [e2g_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [e2g_pkg::CSR_DATA_W-1:0]          csr_write_data,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [e2g_pkg::ANGLE_W-1:0]      latitude,
   output logic signed [e2g_pkg::ANGLE_W-1:0]      longitude,
   output logic signed [e2g_pkg::HEIGHT_W-1:0]     height
);
   import e2g_pkg::*;

   typedef enum logic [1:0] {U_MUL, U_SQRT, U_DIV, U_CORDIC} unit_type;

   localparam logic signed [ANG_W-1:0]   ANG_Q30   = 34'sd1073741824;
   localparam logic signed [ANG_W-1:0]   ANG_HALF  = 34'sd2147483648;
   localparam logic signed [CORD_W-1:0]  CORD_Q30  = 64'sd1073741824;
   localparam logic signed [CORD_W-1:0]  CORD_GAIN = 64'sd652032874;
   localparam logic [30:0]               K_ONE     = 31'h4000_0000;
   localparam logic [41:0]               QUOT_SAT  = 42'h200_0000_0000;
   localparam logic signed [42:0]        H_MAX     = 43'sd549755813887;
   localparam logic signed [42:0]        H_MIN     = -43'sd549755813888;
   localparam logic [32:0]               W_ONE     = 33'h1_0000_0000;
   localparam logic [33:0]               TWO_33    = 34'h2_0000_0000;

   function automatic unit_type unit_of(input op_type op);
      unit_type u;
      unique case (op)
         OP_R, OP_Q:          u = U_SQRT;
         OP_N, OP_TD, OP_HQ:  u = U_DIV;
         OP_LAT, OP_SC, OP_LON: u = U_CORDIC;
         default:             u = U_MUL;
      endcase
      return u;
   endfunction

   function automatic logic [CNT_W-1:0] last_cnt(input unit_type u);
      logic [CNT_W-1:0] c;
      unique case (u)
         U_MUL:    c = CNT_W'(MUL_W - 1);
         U_SQRT:   c = CNT_W'(ROOT_W - 1);
         U_DIV:    c = CNT_W'(DIV_W - 1);
         U_CORDIC: c = CNT_W'(30);
         default:  c = '0;
      endcase
      return c;
   endfunction

   // configuration
   logic [AXIS_W-1:0] axis_ff;
   logic [FLAT_W-1:0] flat_ff;

   // working values
   logic signed [COORD_W-1:0] x_ff, y_ff, z_ff;
   logic [31:0]               e2_ff;
   logic [PROD_W-1:0]         acc_ff;
   logic [ROOT_W-1:0]         r_ff;
   logic [32:0]               s2_ff, w_ff;
   logic [31:0]               q_ff;
   logic [33:0]               n_ff;
   logic [30:0]               k_ff;
   logic [39:0]               rr_ff;
   logic signed [ANG_W-1:0]   phi_ff;
   logic [30:0]               cs_ff;
   logic signed [31:0]        sn_ff;
   logic signed [39:0]        h_ff;
   logic [31:0]               lon_ff;

   // unit sequencing
   logic             busy_ff, done;
   op_type           op_ff;
   logic [CNT_W-1:0] cnt_ff;

   // multiplier
   logic [MUL_W-1:0]  ma_ff, mul_a, mul_b;
   logic [PROD_W-1:0] mp_ff, mp_in;
   logic [MUL_W:0]    msum;

   // square root
   logic [PROD_W-1:0] rad_ff, rad_in, rad_start;
   logic [REM_W-1:0]  rem_ff, rem_in, rs, trial;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic              sge;

   // divider
   logic [DIV_W-1:0]  dvd_ff, dvd_in, dvd_start;
   logic [DVS_W-1:0]  drem_ff, drem_in, dvs_ff, dvs_start;
   logic [DVS_W:0]    ds, dd;
   logic              dge;

   // CORDIC
   logic signed [CORD_W-1:0] cx_ff, cy_ff, cx_in, cy_in, sx, sy, cx_start, cy_start;
   logic signed [ANG_W-1:0]  cz_ff, cz_in, cz_start, tab;
   logic signed [COORD_W:0]  vin_x, vin_y, xn, yn;
   logic                     vec_ff, czero_ff, up, vzero;

   // derived
   logic [30:0]          sn_mag;
   logic signed [40:0]   d_val;
   logic                 d_pos;
   logic [30:0]          k_new, cs_new;
   logic signed [31:0]   sn_new;
   logic [41:0]          quot;
   logic signed [42:0]   hraw;
   logic signed [39:0]   h_new;
   logic signed [ANG_W-1:0] ang_done;

   // output register
   logic                       out_valid_ff;
   logic signed [ANGLE_W-1:0]  lat_out_ff, lon_out_ff;
   logic signed [HEIGHT_W-1:0] hgt_out_ff;

   assign sn_mag = sn_ff[31] ? 31'(-sn_ff) : sn_ff[30:0];
   assign d_val  = $signed({7'b0, n_ff}) + $signed({h_ff[39], h_ff});
   assign d_pos  = !d_val[40] && (d_val != '0);

   // operand selection at unit start
   always_comb begin
      mul_a     = '0;
      mul_b     = '0;
      rad_start = '0;
      dvd_start = '0;
      dvs_start = DVS_W'(1);
      vin_x     = '0;
      vin_y     = '0;
      unique case (cmd.op)
         OP_E2: begin
            mul_a = {9'b0, flat_ff};
            mul_b = {6'b0, TWO_33 - {3'b0, flat_ff}};
         end
         OP_XX: begin
            mul_a = coord_mag(x_ff);
            mul_b = coord_mag(x_ff);
         end
         OP_YY: begin
            mul_a = coord_mag(y_ff);
            mul_b = coord_mag(y_ff);
         end
         OP_S2: begin
            mul_a = {9'b0, sn_mag};
            mul_b = {9'b0, sn_mag};
         end
         OP_W: begin
            mul_a = {8'b0, e2_ff};
            mul_b = {7'b0, s2_ff};
         end
         OP_TM: begin
            mul_a = {10'b0, e2_ff[31:2]};
            mul_b = {6'b0, n_ff};
         end
         OP_RR: begin
            mul_a = r_ff;
            mul_b = {9'b0, k_ff};
         end
         OP_R: rad_start = acc_ff;
         OP_Q: rad_start = {17'b0, w_ff, 30'b0};
         OP_N: begin
            dvd_start = {6'b0, axis_ff, 31'b0};
            dvs_start = {8'b0, q_ff};
         end
         OP_TD: begin
            dvd_start = {6'b0, acc_ff[63:0]};
            dvs_start = d_pos ? d_val[39:0] : DVS_W'(1);
         end
         OP_HQ: begin
            dvd_start = {r_ff, 30'b0};
            dvs_start = (cs_ff == '0) ? DVS_W'(1) : {9'b0, cs_ff};
         end
         OP_LAT: begin
            vin_x = $signed({1'b0, rr_ff});
            vin_y = $signed({z_ff[39], z_ff});
         end
         OP_LON: begin
            vin_x = $signed({x_ff[39], x_ff});
            vin_y = $signed({y_ff[39], y_ff});
         end
         default: begin
         end
      endcase
   end

   // vectoring prerotation by pi for negative x
   always_comb begin
      vzero = (vin_x == '0) && (vin_y == '0);
      xn    = vin_x[COORD_W] ? -vin_x : vin_x;
      yn    = vin_x[COORD_W] ? -vin_y : vin_y;
      if (cmd.op == OP_SC) begin
         cx_start = CORD_GAIN;
         cy_start = '0;
         cz_start = phi_ff;
      end else begin
         cx_start = $signed({{3{xn[COORD_W]}}, xn, 20'b0});
         cy_start = $signed({{3{yn[COORD_W]}}, yn, 20'b0});
         if (!vin_x[COORD_W]) begin
            cz_start = '0;
         end else begin
            cz_start = vin_y[COORD_W] ? -ANG_HALF : ANG_HALF;
         end
      end
   end

   // one step of each unit
   always_comb begin
      msum  = {1'b0, mp_ff[PROD_W-1:MUL_W]} + (mp_ff[0] ? {1'b0, ma_ff} : '0);
      mp_in = {msum, mp_ff[MUL_W-1:1]};

      rs      = {rem_ff[40:0], rad_ff[PROD_W-1:PROD_W-2]};
      trial   = {1'b0, root_ff, 2'b01};
      sge     = (rs >= trial);
      rem_in  = sge ? rs - trial : rs;
      root_in = {root_ff[ROOT_W-2:0], sge};
      rad_in  = {rad_ff[PROD_W-3:0], 2'b00};

      ds      = {drem_ff, dvd_ff[DIV_W-1]};
      dd      = ds - {1'b0, dvs_ff};
      dge     = (ds >= {1'b0, dvs_ff});
      drem_in = dge ? dd[DVS_W-1:0] : ds[DVS_W-1:0];
      dvd_in  = {dvd_ff[DIV_W-2:0], dge};

      sx  = cx_ff >>> cnt_ff[STEP_W-1:0];
      sy  = cy_ff >>> cnt_ff[STEP_W-1:0];
      tab = $signed({4'b0, atan_entry(cnt_ff[STEP_W-1:0])});
      up  = vec_ff ? (cy_ff > 64'sd0) : cz_ff[ANG_W-1];
      cx_in = up ? cx_ff + sy : cx_ff - sy;
      cy_in = up ? cy_ff - sx : cy_ff + sx;
      cz_in = up ? cz_ff + tab : cz_ff - tab;
   end

   // results of finished steps
   always_comb begin
      ang_done = czero_ff ? '0 : cz_in;

      k_new = (!d_pos || (dvd_in[DIV_W-1:30] != '0)) ? '0 : K_ONE - {1'b0, dvd_in[29:0]};

      if (cx_in < 64'sd0) begin
         cs_new = '0;
      end else if (cx_in > CORD_Q30) begin
         cs_new = K_ONE;
      end else begin
         cs_new = cx_in[30:0];
      end
      if (cy_in < -CORD_Q30) begin
         sn_new = -32'sd1073741824;
      end else if (cy_in > CORD_Q30) begin
         sn_new = 32'sd1073741824;
      end else begin
         sn_new = cy_in[31:0];
      end

      // polar axis gives zero, zero cosine or a huge quotient saturates
      priority if (r_ff == '0) begin
         quot = '0;
      end else if (cs_ff == '0 || dvd_in[DIV_W-1:41] != '0) begin
         quot = QUOT_SAT;
      end else begin
         quot = {1'b0, dvd_in[40:0]};
      end
      hraw = $signed({1'b0, quot}) - $signed({9'b0, n_ff});
      priority if (hraw > H_MAX) begin
         h_new = H_MAX[39:0];
      end else if (hraw < H_MIN) begin
         h_new = H_MIN[39:0];
      end else begin
         h_new = hraw[39:0];
      end
   end

   assign done = busy_ff && (cnt_ff == last_cnt(unit_of(op_ff)));

   assign status.done     = done;
   assign status.out_busy = out_valid_ff && !rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff      <= AXIS_RESET;
         flat_ff      <= FLAT_RESET;
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            unique case (csr_index_type'(csr_index))
               CSR_SEMI_MAJOR: axis_ff <= csr_write_data[AXIS_W-1:0];
               CSR_FLATTENING: flat_ff <= csr_write_data[FLAT_W-1:0];
               default: begin
               end
            endcase
         end
         if (cmd.start) begin
            busy_ff <= 1'b1;
         end else if (done) begin
            busy_ff <= 1'b0;
         end
         if (cmd.publish) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff   <= in_x;
         y_ff   <= in_y;
         z_ff   <= in_z;
         sn_ff  <= '0;
         h_ff   <= '0;
         phi_ff <= '0;
      end
      if (cmd.start) begin
         op_ff    <= cmd.op;
         cnt_ff   <= '0;
         ma_ff    <= mul_a;
         mp_ff    <= {{(PROD_W-MUL_W){1'b0}}, mul_b};
         rad_ff   <= rad_start;
         rem_ff   <= '0;
         root_ff  <= '0;
         dvd_ff   <= dvd_start;
         drem_ff  <= '0;
         dvs_ff   <= dvs_start;
         cx_ff    <= cx_start;
         cy_ff    <= cy_start;
         cz_ff    <= cz_start;
         vec_ff   <= (cmd.op != OP_SC);
         czero_ff <= (cmd.op != OP_SC) && vzero;
      end else if (busy_ff) begin
         cnt_ff  <= cnt_ff + CNT_W'(1);
         mp_ff   <= mp_in;
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
         dvd_ff  <= dvd_in;
         drem_ff <= drem_in;
         cx_ff   <= cx_in;
         cy_ff   <= cy_in;
         cz_ff   <= cz_in;
      end
      if (done) begin
         unique case (op_ff)
            OP_E2:  e2_ff  <= mp_in[63:32];
            OP_XX:  acc_ff <= mp_in;
            OP_YY:  acc_ff <= acc_ff + mp_in;
            OP_R:   r_ff   <= root_in;
            OP_S2:  s2_ff  <= mp_in[60:28];
            OP_W:   w_ff   <= W_ONE - {1'b0, mp_in[63:32]};
            OP_Q:   q_ff   <= root_in[31:0];
            OP_N:   n_ff   <= dvd_in[33:0];
            OP_TM:  acc_ff <= mp_in;
            OP_TD:  k_ff   <= k_new;
            OP_RR:  rr_ff  <= mp_in[69:30];
            OP_LAT: phi_ff <= ang_done;
            OP_SC: begin
               cs_ff <= cs_new;
               sn_ff <= sn_new;
            end
            OP_HQ:  h_ff   <= h_new;
            OP_LON: lon_ff <= ang_done[31:0];
            default: begin
            end
         endcase
      end
      if (cmd.publish) begin
         if (phi_ff > ANG_Q30) begin
            lat_out_ff <= 32'sd1073741824;
         end else if (phi_ff < -ANG_Q30) begin
            lat_out_ff <= -32'sd1073741824;
         end else begin
            lat_out_ff <= phi_ff[31:0];
         end
         lon_out_ff <= lon_ff;
         hgt_out_ff <= h_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign latitude  = lat_out_ff;
   assign longitude = lon_out_ff;
   assign height    = hgt_out_ff;

   `ASSERT_RST(a_start_idle, cmd.start |-> !busy_ff, "unit started while busy")
   `ASSERT_RST(a_publish_room, cmd.publish |-> (!out_valid_ff || rsp_ready), "result overwritten")
   `ASSERT_RST(a_lat_range, out_valid_ff |-> (lat_out_ff <= 32'sd1073741824 && lat_out_ff >= -32'sd1073741824), "latitude out of range")

endmodule

// ===== rtl/ecef_to_geodetic.sv =====
// ECEF to geodetic conversion.
// req_bus carries one word per position: ecef_x/y/z in signed mm. A word is
// taken when valid and ready are both high; ready is high while the block
// has no position in work.
// rsp_bus returns one word per position: latitude and longitude as binary
// angles (2^31 = pi) and the ellipsoidal height in mm.
// csr_write_en/csr_index/csr_write_data write the semi-major axis (index 0)
// and the flattening (index 1); write them only while the block is idle.
// Setup ops run once, then ITERATIONS passes of the latitude and height
// ops, then the longitude op; the result is then published. One position
// is in work at a time and ready returns the cycle after publish, so the
// next position is taken only after the last one is published.
// The ops run on the shared serial units: a 40-step shift-add
// multiplier, a 40-step square root, a 70-step restoring divider and a
// 31-step CORDIC; each op is issued and then stepped through to its end.
// A finished result sits in an output register; the next position is taken
// while it waits. If that result is still stalled when the next one is
// done, the controller holds until rsp ready frees the register.
// Synchronous reset returns to idle, drops rsp valid and reloads the
// default WGS-84 axis and flattening.
module ecef_to_geodetic #(
   parameter int ITERATIONS = e2g_pkg::ITERATIONS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   e2g_req_if.sink                           req_bus,
   e2g_rsp_if.source                         rsp_bus,
   input  logic                              csr_write_en,
   input  logic [e2g_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [e2g_pkg::CSR_DATA_W-1:0]    csr_write_data
);
   import e2g_pkg::*;

   cmd_type    cmd;      // controller to datapath
   status_type status;   // datapath to controller

   // sequencer: op order, pass count, input/output handshake
   e2g_ctrl #(
      .ITERATIONS (ITERATIONS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // working registers, shared arithmetic units, output register
   e2g_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .in_x           (req_bus.ecef_x),
      .in_y           (req_bus.ecef_y),
      .in_z           (req_bus.ecef_z),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .rsp_valid      (rsp_bus.valid),
      .rsp_ready      (rsp_bus.ready),
      .latitude       (rsp_bus.latitude),
      .longitude      (rsp_bus.longitude),
      .height         (rsp_bus.height)
   );

endmodule
